### design/sif_pkg.sv
`default_nettype none

package sif_pkg;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned PAT_BYTES = 32;
  localparam int unsigned PLEN_W    = 6;
  localparam int unsigned LIMIT_W   = 16;
  localparam int unsigned APB_DW    = 64;
  localparam int unsigned APB_AW    = 6;
  localparam int unsigned REG_IDX_W = 3;

  typedef enum logic [1:0] {
    MODE_CONTAINS = 2'd0,
    MODE_LACKS    = 2'd1,
    MODE_AT_MOST  = 2'd2,
    MODE_AT_LEAST = 2'd3
  } filter_mode_e;

  localparam logic [REG_IDX_W-1:0] REG_FILTER_MODE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAT_LEN     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LEN_LIMIT   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PAT_BYTES_0 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PAT_BYTES_1 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PAT_BYTES_2 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PAT_BYTES_3 = 3'd6;

endpackage

`default_nettype wire

### design/sif_in_if.sv
`default_nettype none

interface sif_in_if import sif_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            last;
  logic            empty_item;

  modport source (output valid, ch, last, empty_item, input ready);
  modport sink (input valid, ch, last, empty_item, output ready);
endinterface

`default_nettype wire

### design/sif_out_if.sv
`default_nettype none

interface sif_out_if import sif_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               keep;
  logic [COUNT_W-1:0] item_length;

  modport source (output valid, keep, item_length, input ready);
  modport sink (input valid, keep, item_length, output ready);
endinterface

`default_nettype wire

### design/string_item_filter_unit.sv
`default_nettype none

// Keeps or drops text items that stream in one character per transaction, the
// final character flagged by last (an empty item is a single transaction with
// empty_item and last set). One character is taken every cycle while the output
// is not stalled; after the last character is accepted, the result moves from
// the input register to the result register and is held until taken. Pattern
// search keeps one
// prefix-match bit per pattern position, updated from a parallel compare of
// the incoming character against every pattern byte, so a match must lie
// wholly inside the item. The length count saturates at 65535. Configure over
// the APB port (64-bit registers at byte address 8*i) only while no item is in
// flight.
module string_item_filter_unit import sif_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 32
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  sif_in_if.sink              in_i,
  sif_out_if.source           out_o,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [APB_AW-1:0]   paddr,
  input  wire  [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  filter_mode_e                 mode_q;
  logic [PLEN_W-1:0]            pat_len_q;
  logic [LIMIT_W-1:0]           limit_q;
  logic [PAT_BYTES-1:0][CH_W-1:0] pat_q;

  logic                         s1_valid_q;
  logic [CH_W-1:0]              s1_ch_q;
  logic                         s1_last_q;
  logic                         s1_empty_q;

  logic [PATTERN_MAX-1:0]       hit_q;
  logic [PATTERN_MAX-1:0]       hit_d;
  logic [PATTERN_MAX-1:0]       byte_eq;
  logic [PATTERN_MAX-1:0]       len_sel;
  logic [COUNT_W-1:0]           count_q;
  logic [COUNT_W-1:0]           count_inc;
  logic [COUNT_W-1:0]           count_fin;
  logic                         found_q;
  logic                         found_fin;
  logic                         match;

  logic                         out_valid_q;
  logic                         keep_q;
  logic                         keep_d;
  logic [COUNT_W-1:0]           len_q;

  logic                         advance;
  logic                         step;
  logic                         act;
  logic                         done;
  logic                         cfg_wr;
  logic [REG_IDX_W-1:0]         reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1 -: REG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_CONTAINS;
      pat_len_q <= '0;
      limit_q   <= '0;
      pat_q     <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FILTER_MODE: mode_q <= filter_mode_e'(pwdata[1:0]);
        REG_PAT_LEN:     pat_len_q <= pwdata[PLEN_W-1:0];
        REG_LEN_LIMIT:   limit_q <= pwdata[LIMIT_W-1:0];
        REG_PAT_BYTES_0: pat_q[7:0] <= pwdata;
        REG_PAT_BYTES_1: pat_q[15:8] <= pwdata;
        REG_PAT_BYTES_2: pat_q[23:16] <= pwdata;
        REG_PAT_BYTES_3: pat_q[31:24] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FILTER_MODE: prdata = APB_DW'(mode_q);
      REG_PAT_LEN:     prdata = APB_DW'(pat_len_q);
      REG_LEN_LIMIT:   prdata = APB_DW'(limit_q);
      REG_PAT_BYTES_0: prdata = pat_q[7:0];
      REG_PAT_BYTES_1: prdata = pat_q[15:8];
      REG_PAT_BYTES_2: prdata = pat_q[23:16];
      REG_PAT_BYTES_3: prdata = pat_q[31:24];
      default:         prdata = '0;
    endcase
  end

  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || advance;
  assign step       = s1_valid_q && advance;
  assign act        = step && !(s1_empty_q && !s1_last_q);
  assign done       = step && s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_ch_q    <= in_i.ch;
      s1_last_q  <= in_i.last;
      s1_empty_q <= in_i.empty_item;
    end
  end

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_pos
    assign byte_eq[k] = (s1_ch_q == pat_q[k]);
    assign len_sel[k] = (pat_len_q == PLEN_W'(k + 1)) ||
                        ((k == PATTERN_MAX - 1) && (pat_len_q > PLEN_W'(PATTERN_MAX)));
    if (k == 0) begin : g_first
      assign hit_d[k] = byte_eq[k];
    end else begin : g_rest
      assign hit_d[k] = hit_q[k-1] && byte_eq[k];
    end
  end

  assign match     = (pat_len_q == '0) || |(hit_d & len_sel);
  assign count_inc = (count_q == '1) ? count_q : count_q + COUNT_W'(1);
  assign count_fin = s1_empty_q ? count_q : count_inc;
  assign found_fin = found_q || (!s1_empty_q && match);

  always_comb begin
    case (mode_q)
      MODE_CONTAINS: keep_d = found_fin;
      MODE_LACKS:    keep_d = !found_fin;
      MODE_AT_MOST:  keep_d = (count_fin <= limit_q);
      MODE_AT_LEAST: keep_d = (count_fin >= limit_q);
      default:       keep_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= '0;
      count_q <= '0;
      found_q <= 1'b0;
    end else if (act) begin
      if (s1_last_q) begin
        hit_q   <= '0;
        count_q <= '0;
        found_q <= 1'b0;
      end else begin
        hit_q   <= hit_d;
        count_q <= count_inc;
        found_q <= found_fin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      keep_q <= keep_d;
      len_q  <= count_fin;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.keep        = keep_q;
  assign out_o.item_length = len_q;

  a_hit_needs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_q != '0) |-> (count_q != '0))
    else $error("prefix match recorded with no characters counted");

  a_found_needs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (count_q != '0))
    else $error("found flag set with no characters counted");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> (count_q == '0) && (hit_q == '0) && !found_q)
    else $error("item state not cleared after last character");

  a_contains_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && keep_q && (mode_q == MODE_CONTAINS)) |-> (len_q != '0))
    else $error("empty item reported as containing the pattern");

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sif_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned RANDOM_CHARS   = 800;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
    logic            empty_item;
  } char_beat_t;

  typedef struct packed {
    logic               keep;
    logic [COUNT_W-1:0] item_length;
  } verdict_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic            in_valid  = 1'b0;
  logic [CH_W-1:0] in_ch     = '0;
  logic            in_last   = 1'b0;
  logic            in_empty  = 1'b0;
  logic            out_ready = 1'b0;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  sif_in_if  in_bus ();
  sif_out_if out_bus ();

  assign in_bus.valid      = in_valid;
  assign in_bus.ch         = in_ch;
  assign in_bus.last       = in_last;
  assign in_bus.empty_item = in_empty;
  assign out_bus.ready     = out_ready;

  string_item_filter_unit #(.PATTERN_MAX(PAT_BYTES)) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  filter_mode_e       mode_shadow;
  logic [PLEN_W-1:0]  plen_shadow;
  logic [LIMIT_W-1:0] limit_shadow;
  logic [APB_DW-1:0]  pattern_shadow [4];
  logic [CH_W-1:0]    recent_chars [PAT_BYTES];
  logic [COUNT_W-1:0] chars_seen;
  logic               pattern_seen;

  char_beat_t      pending_beats [$];
  verdict_t        expected_verdicts [$];
  logic [CH_W-1:0] text_buf [$];
  logic [CH_W-1:0] pattern_plan [PAT_BYTES];
  logic [CH_W-1:0] alphabet [4];

  int unsigned beats_queued     = 0;
  int unsigned beats_accepted   = 0;
  int unsigned chars_queued     = 0;
  int unsigned items_queued     = 0;
  int unsigned results_checked  = 0;
  int unsigned kept_count       = 0;
  int unsigned error_count      = 0;
  int unsigned settings_applied = 0;
  int unsigned straddle_from    = 0;
  bit          steady_flow      = 1'b0;

  function automatic logic [CH_W-1:0] pattern_byte(int unsigned k);
    return pattern_shadow[k / 8][(k % 8) * 8 +: 8];
  endfunction

  function automatic void clear_item();
    foreach (recent_chars[i]) recent_chars[i] = '0;
    chars_seen   = '0;
    pattern_seen = 1'b0;
  endfunction

  function automatic bit window_holds_pattern();
    int unsigned span;
    span = (plen_shadow > PAT_BYTES) ? PAT_BYTES : int'(plen_shadow);
    if (chars_seen < span || chars_seen == 0) return 1'b0;
    for (int unsigned k = 0; k < span; k++)
      if (recent_chars[span - 1 - k] != pattern_byte(k)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void track_char(char_beat_t b);
    verdict_t v;
    if (b.empty_item && !b.last) return;
    if (!b.empty_item) begin
      for (int i = PAT_BYTES - 1; i > 0; i--) recent_chars[i] = recent_chars[i - 1];
      recent_chars[0] = b.ch;
      if (chars_seen != '1) chars_seen = chars_seen + 1'b1;
      if (window_holds_pattern()) pattern_seen = 1'b1;
    end
    if (!b.last) return;
    case (mode_shadow)
      MODE_CONTAINS: v.keep = pattern_seen;
      MODE_LACKS:    v.keep = !pattern_seen;
      MODE_AT_MOST:  v.keep = (chars_seen <= limit_shadow);
      default:       v.keep = (chars_seen >= limit_shadow);
    endcase
    v.item_length = chars_seen;
    expected_verdicts.push_back(v);
    clear_item();
  endfunction

  function automatic int unsigned draw_gap();
    int unsigned r;
    if (steady_flow) return 0;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CH_W-1:0] pick_char();
    if ($urandom_range(4) < 3) return alphabet[$urandom_range(3)];
    return CH_W'($urandom);
  endfunction

  function automatic void push_beat(logic [CH_W-1:0] ch, logic last, logic empty_item);
    char_beat_t b;
    b.ch         = ch;
    b.last       = last;
    b.empty_item = empty_item;
    pending_beats.push_back(b);
    beats_queued++;
    if (!empty_item) chars_queued++;
  endfunction

  function automatic void push_pattern(int unsigned from, int unsigned upto);
    for (int unsigned k = from; k < upto; k++) text_buf.push_back(pattern_byte(k));
  endfunction

  // drain text_buf as one item, scattering ignored transactions in between
  function automatic void queue_item(bit close_with_empty);
    foreach (text_buf[i]) begin
      if ($urandom_range(15) == 0) push_beat(CH_W'($urandom), 1'b0, 1'b1);
      push_beat(text_buf[i], !close_with_empty && i == text_buf.size() - 1, 1'b0);
    end
    if (close_with_empty || text_buf.size() == 0) push_beat(CH_W'($urandom), 1'b1, 1'b1);
    items_queued++;
    text_buf.delete();
  endfunction

  function automatic void build_random_text();
    int unsigned span, n, pos, cut, flip;
    span = (plen_shadow > PAT_BYTES) ? PAT_BYTES : int'(plen_shadow);
    if (straddle_from != 0) begin
      push_pattern(straddle_from, span);
      straddle_from = 0;
    end
    n = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(span + 6);
    repeat (n) text_buf.push_back(pick_char());
    n = text_buf.size();
    if (span != 0 && n >= span && $urandom_range(1) == 1) begin
      pos = $urandom_range(n - span);
      for (int unsigned k = 0; k < span; k++) text_buf[pos + k] = pattern_byte(k);
      if ($urandom_range(3) == 0) begin
        flip = pos + $urandom_range(span - 1);
        text_buf[flip] = text_buf[flip] ^ CH_W'($urandom_range(1, 255));
      end
    end
    // end on a pattern prefix; the next item may start with the rest
    if (span > 1 && n != 0 && $urandom_range(5) == 0) begin
      cut = $urandom_range(1, span - 1);
      if (cut > n) cut = n;
      for (int unsigned k = 0; k < cut; k++) text_buf[n - cut + k] = pattern_byte(k);
      straddle_from = cut;
    end
  endfunction

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FILTER_MODE: mode_shadow  = filter_mode_e'(value[1:0]);
      REG_PAT_LEN:     plen_shadow  = value[PLEN_W-1:0];
      REG_LEN_LIMIT:   limit_shadow = value[LIMIT_W-1:0];
      default:         pattern_shadow[idx - REG_PAT_BYTES_0] = value;
    endcase
  endtask

  task automatic configure(filter_mode_e mode, logic [PLEN_W-1:0] plen,
                           logic [LIMIT_W-1:0] limit);
    logic [APB_DW-1:0] word;
    write_reg(REG_FILTER_MODE, APB_DW'(mode));
    write_reg(REG_PAT_LEN, APB_DW'(plen));
    write_reg(REG_LEN_LIMIT, APB_DW'(limit));
    for (int w = 0; w < 4; w++) begin
      for (int n = 0; n < 8; n++) word[n * 8 +: 8] = pattern_plan[w * 8 + n];
      write_reg(REG_IDX_W'(REG_PAT_BYTES_0 + w), word);
    end
    settings_applied++;
  endtask

  task automatic random_setting();
    filter_mode_e       mode;
    logic [PLEN_W-1:0]  plen;
    logic [LIMIT_W-1:0] limit;
    mode = filter_mode_e'($urandom_range(3));
    case ($urandom_range(5))
      0:       plen = '0;
      1:       plen = PLEN_W'($urandom_range(1, 3));
      2:       plen = PLEN_W'($urandom_range(4, PAT_BYTES - 1));
      3:       plen = PLEN_W'(PAT_BYTES);
      4:       plen = PLEN_W'($urandom_range(PAT_BYTES + 1, 63));
      default: plen = PLEN_W'($urandom_range(1, 8));
    endcase
    case ($urandom_range(7))
      0:       limit = '0;
      1:       limit = '1;
      default: limit = LIMIT_W'($urandom_range(24));
    endcase
    foreach (alphabet[i]) alphabet[i] = CH_W'($urandom);
    foreach (pattern_plan[k]) pattern_plan[k] = pick_char();
    configure(mode, plen, limit);
  endtask

  task automatic settle();
    while (beats_accepted != beats_queued || expected_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // driver
  char_beat_t  beat_on_bus;
  int unsigned send_gap;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_bus.ready) begin
        track_char(beat_on_bus);
        beats_accepted++;
      end
      if (!in_valid || in_bus.ready) begin
        if (send_gap != 0 || pending_beats.size() == 0) begin
          if (send_gap != 0) send_gap--;
          in_valid <= 1'b0;
        end else begin
          beat_on_bus = pending_beats.pop_front();
          in_valid <= 1'b1;
          in_ch    <= beat_on_bus.ch;
          in_last  <= beat_on_bus.last;
          in_empty <= beat_on_bus.empty_item;
          send_gap = draw_gap();
        end
      end
    end
  end

  // monitor
  int unsigned stall_left;

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_bus.valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected result keep=%0b item_length=%0d", $time,
                   out_bus.keep, out_bus.item_length);
          error_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_bus.keep !== want.keep) begin
            $display("%0t: keep expected %0b, actual %0b", $time, want.keep, out_bus.keep);
            error_count++;
          end
          if (out_bus.item_length !== want.item_length) begin
            $display("%0t: item_length expected %0d, actual %0d", $time,
                     want.item_length, out_bus.item_length);
            error_count++;
          end
          results_checked++;
          if (want.keep) kept_count++;
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = draw_gap();
      end
    end
  end

  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_valid && in_bus.ready) || (out_bus.valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned random_goal, phase_goal;
    mode_shadow  = MODE_CONTAINS;
    plen_shadow  = '0;
    limit_shadow = '0;
    foreach (pattern_shadow[w]) pattern_shadow[w] = '0;
    clear_item();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: empty pattern matches any nonempty item
    queue_item(1'b0);
    text_buf.push_back(8'h00);
    queue_item(1'b0);
    text_buf.push_back(8'hFF);
    queue_item(1'b1);
    settle();

    foreach (pattern_plan[k]) pattern_plan[k] = CH_W'($urandom);
    pattern_plan[0]             = 8'h00;
    pattern_plan[PAT_BYTES - 1] = 8'hFF;
    configure(MODE_CONTAINS, PLEN_W'(PAT_BYTES), '0);
    push_pattern(0, PAT_BYTES);
    queue_item(1'b0);
    push_pattern(0, PAT_BYTES);
    text_buf[PAT_BYTES - 1] = 8'hFE;
    queue_item(1'b0);
    push_pattern(0, PAT_BYTES - 1);
    queue_item(1'b1);
    repeat (5) text_buf.push_back(CH_W'($urandom));
    push_pattern(0, PAT_BYTES);
    repeat (3) text_buf.push_back(CH_W'($urandom));
    queue_item(1'b1);
    push_pattern(0, PAT_BYTES / 2);
    queue_item(1'b0);
    push_pattern(PAT_BYTES / 2, PAT_BYTES);
    queue_item(1'b0);
    settle();

    // oversized pattern length clamps to the full window
    foreach (pattern_plan[k]) pattern_plan[k] = 8'hFF;
    configure(MODE_LACKS, PLEN_W'(63), '0);
    repeat (PAT_BYTES) text_buf.push_back(8'hFF);
    queue_item(1'b0);
    repeat (PAT_BYTES - 1) text_buf.push_back(8'hFF);
    queue_item(1'b0);
    repeat (40) text_buf.push_back(8'hFF);
    queue_item(1'b1);
    settle();

    configure(MODE_AT_MOST, '0, '0);
    queue_item(1'b0);
    text_buf.push_back(CH_W'($urandom));
    queue_item(1'b0);
    settle();
    configure(MODE_AT_MOST, '0, LIMIT_W'(3));
    repeat (3) text_buf.push_back(CH_W'($urandom));
    queue_item(1'b0);
    repeat (4) text_buf.push_back(CH_W'($urandom));
    queue_item(1'b1);
    settle();
    configure(MODE_AT_LEAST, '0, '0);
    queue_item(1'b1);
    settle();

    random_goal = chars_queued + RANDOM_CHARS;
    while (chars_queued < random_goal) begin
      random_setting();
      steady_flow   = ($urandom_range(3) == 0);
      straddle_from = 0;
      phase_goal    = chars_queued + $urandom_range(100, 200);
      while (chars_queued < phase_goal) begin
        build_random_text();
        queue_item($urandom_range(7) == 0);
      end
      settle();
    end

    $display("Covered %0d items in %0d transactions under %0d filter settings",
             items_queued, beats_accepted, settings_applied);
    $display("Checked %0d results: %0d kept, %0d dropped",
             results_checked, kept_count, results_checked - kept_count);
    if (error_count == 0 && expected_verdicts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
